// File: rtl/tlvp_pkg.sv
// Shared types and codes for the TLV message parser.
`default_nettype none

package tlvp_pkg;

  localparam int OUT_QUEUE_DEPTH = 4;

  localparam logic [2:0] KIND_HDR_OK   = 3'd0;
  localparam logic [2:0] KIND_VALUE    = 3'd1;
  localparam logic [2:0] KIND_EMPTY    = 3'd2;
  localparam logic [2:0] KIND_ACCEPT   = 3'd3;
  localparam logic [2:0] KIND_REJECT   = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_VERSION   = 3'd2;
  localparam logic [2:0] ERR_DECL_LEN  = 3'd3;
  localparam logic [2:0] ERR_PARAM_LEN = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_type;
    logic [15:0] tag;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        param_last;
    logic [2:0]  error_code;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

  function automatic out_item_t make_res(logic [2:0] kind, logic [7:0] cls, logic [7:0] typ,
                                         logic [15:0] tag, logic [7:0] vb,
                                         logic [15:0] vi, logic pl, logic [2:0] err);
    out_item_t r;
    r.kind        = kind;
    r.msg_class   = cls;
    r.msg_type    = typ;
    r.tag         = tag;
    r.value_byte  = vb;
    r.value_index = vi;
    r.param_last  = pl;
    r.error_code  = err;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tlvp_parser.sv
// Frame state and per-byte header and parameter decode.
`default_nettype none

module tlvp_parser import tlvp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t item,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_data,
  output push_t         push
);

  typedef enum logic [2:0] {PH_IDLE, PH_HDR, PH_PHDR, PH_VAL, PH_PAD} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  version_r;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] ft_r, ft_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [7:0]  cls_r, cls_nxt;
  logic [7:0]  typ_r, typ_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] vc_r, vc_nxt;
  logic [1:0]  pad_r, pad_nxt;

  always_comb begin
    logic [15:0] idx;
    logic [16:0] span;
    logic [17:0] np;
    logic [1:0]  pad;
    logic        last;
    logic        go;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ft_nxt    = ft_r;
    dl_nxt    = dl_r;
    cls_nxt   = cls_r;
    typ_nxt   = typ_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    vc_nxt    = vc_r;
    pad_nxt   = pad_r;
    push      = '0;
    idx       = '0;
    span      = '0;
    np        = '0;
    pad       = '0;
    last      = 1'b0;
    go        = accept;
    if (accept && item.first) begin
      ft_nxt    = item.frame_length;
      pos_nxt   = '0;
      dl_nxt    = '0;
      cls_nxt   = '0;
      typ_nxt   = '0;
      tag_nxt   = '0;
      len_nxt   = '0;
      vc_nxt    = '0;
      pad_nxt   = '0;
      phase_nxt = PH_HDR;
      if (item.frame_length < 16'd8) begin
        phase_nxt  = PH_IDLE;
        push.count = 2'd1;
        push.res0  = make_res(KIND_REJECT, '0, '0, '0, '0, '0, 1'b0, ERR_SHORT);
        go         = 1'b0;
      end
    end
    if (go && phase_nxt != PH_IDLE) begin
      idx     = pos_nxt;
      pos_nxt = pos_nxt + 16'd1;
      case (phase_nxt)
        PH_HDR: begin
          if (idx == 16'd0) begin
            if (item.data_byte != version_r) begin
              phase_nxt  = PH_IDLE;
              push.count = 2'd1;
              push.res0  = make_res(KIND_REJECT, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                    ERR_VERSION);
            end
          end else if (idx == 16'd2) begin
            cls_nxt = item.data_byte;
          end else if (idx == 16'd3) begin
            typ_nxt = item.data_byte;
          end else if (idx >= 16'd4) begin
            dl_nxt = {dl_nxt[23:0], item.data_byte};
            if (idx == 16'd7) begin
              push.count = 2'd1;
              if (dl_nxt > {16'd0, ft_nxt}) begin
                phase_nxt = PH_IDLE;
                push.res0 = make_res(KIND_REJECT, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                     ERR_DECL_LEN);
              end else begin
                push.res0 = make_res(KIND_HDR_OK, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                     ERR_NONE);
                if (ft_nxt < 16'd12) begin
                  phase_nxt  = PH_IDLE;
                  push.count = 2'd2;
                  push.res1  = make_res(KIND_ACCEPT, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                        ERR_NONE);
                end else begin
                  vc_nxt    = '0;
                  phase_nxt = PH_PHDR;
                end
              end
            end
          end
        end
        PH_PHDR: begin
          if (vc_nxt == 16'd0) begin
            tag_nxt = {item.data_byte, 8'h00};
            vc_nxt  = vc_nxt + 16'd1;
          end else if (vc_nxt == 16'd1) begin
            tag_nxt = {tag_nxt[15:8], item.data_byte};
            vc_nxt  = vc_nxt + 16'd1;
          end else if (vc_nxt == 16'd2) begin
            len_nxt = {item.data_byte, 8'h00};
            vc_nxt  = vc_nxt + 16'd1;
          end else begin
            len_nxt = {len_nxt[15:8], item.data_byte};
            span    = 17'(idx - 16'd3) + {1'b0, len_nxt};
            if (len_nxt < 16'd4 || span > {1'b0, ft_nxt}) begin
              phase_nxt  = PH_IDLE;
              vc_nxt     = vc_nxt + 16'd1;
              push.count = 2'd1;
              push.res0  = make_res(KIND_REJECT, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                    ERR_PARAM_LEN);
            end else if (len_nxt == 16'd4) begin
              push.count = 2'd1;
              push.res0  = make_res(KIND_EMPTY, cls_nxt, typ_nxt, tag_nxt, '0, '0, 1'b0,
                                    ERR_NONE);
              np = 18'(idx) + 18'd1;
              if (np + 18'd4 > 18'(ft_nxt)) begin
                phase_nxt  = PH_IDLE;
                push.count = 2'd2;
                push.res1  = make_res(KIND_ACCEPT, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                      ERR_NONE);
              end else begin
                vc_nxt    = '0;
                phase_nxt = PH_PHDR;
              end
            end else begin
              phase_nxt = PH_VAL;
              vc_nxt    = '0;
            end
          end
        end
        PH_VAL: begin
          last       = (vc_nxt == len_nxt - 16'd5);
          push.count = 2'd1;
          push.res0  = make_res(KIND_VALUE, cls_nxt, typ_nxt, tag_nxt, item.data_byte,
                                vc_nxt, last, ERR_NONE);
          vc_nxt     = vc_nxt + 16'd1;
          if (last) begin
            pad = 2'd0 - len_nxt[1:0];
            np  = 18'(idx) + 18'd1 + 18'(pad);
            if (np + 18'd4 > 18'(ft_nxt)) begin
              phase_nxt  = PH_IDLE;
              push.count = 2'd2;
              push.res1  = make_res(KIND_ACCEPT, cls_nxt, typ_nxt, '0, '0, '0, 1'b0,
                                    ERR_NONE);
            end else begin
              vc_nxt = '0;
              if (pad != 2'd0) begin
                phase_nxt = PH_PAD;
                pad_nxt   = pad;
              end else begin
                phase_nxt = PH_PHDR;
              end
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_nxt - 2'd1;
          if (pad_nxt == 2'd0) begin
            phase_nxt = PH_PHDR;
            vc_nxt    = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (push.count == 2'd1) begin
      push.res0.run_last = 1'b1;
    end else if (push.count == 2'd2) begin
      push.res1.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      version_r <= 8'd1;
      pos_r     <= '0;
      ft_r      <= '0;
      dl_r      <= '0;
      cls_r     <= '0;
      typ_r     <= '0;
      tag_r     <= '0;
      len_r     <= '0;
      vc_r      <= '0;
      pad_r     <= '0;
    end else begin
      if (cfg_we) begin
        version_r <= cfg_data;
      end
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ft_r    <= ft_nxt;
      dl_r    <= dl_nxt;
      cls_r   <= cls_nxt;
      typ_r   <= typ_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      vc_r    <= vc_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tlvp_out_queue.sv
// Result queue: takes up to two items per cycle, delivers one per cycle while out_stall is low.
`default_nettype none

module tlvp_out_queue import tlvp_pkg::*; #(
  parameter int DEPTH = OUT_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       full,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign full      = (cnt_r > CW'(DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_p1     = ptr_inc(wr_r);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push.count) - CW'(pop);
    if (push.count == 2'd1) begin
      wr_nxt = wr_p1;
    end else if (push.count == 2'd2) begin
      wr_nxt = ptr_inc(wr_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tlv_message_parser.sv
// Top level of the streaming TLV message parser.
//
//   channel   dir   handshake            payload
//   in_       in    in_valid / in_stall  in_data   (in_item_t)
//   out_      out   out_valid / out_stall out_data (out_item_t)
//   cfg_      in    cfg_valid / cfg_ready cfg_data (expected version)
//
// One byte is accepted per cycle while in_stall is low; its results enter the result
// queue at that edge and leave on out_ one item per cycle while out_stall is low.
// A byte that causes two results yields two output items; the queue absorbs them.
// in_stall rises while the queue has room for fewer than two items.
// Synchronous reset sets the parser idle, empties the queue and loads version 1.
`default_nettype none

module tlv_message_parser import tlvp_pkg::*; #(
  parameter int QUEUE_DEPTH = OUT_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  push_t push;
  logic  full;

  assign in_stall  = full;
  assign cfg_ready = 1'b1;

  tlvp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_valid && !full),
    .item     (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push)
  );

  tlvp_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
